[rtl/core/sleb_pkg.sv]
package sleb_pkg;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_ESCAPE    = 8'd27;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_DOLLAR    = 8'd36;
  localparam logic [7:0] CH_QUESTION  = 8'd63;

  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_BACK  = 2'd1;
  localparam logic [1:0] OP_ESC   = 2'd2;
  localparam logic [1:0] OP_EXEC  = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } cmd_t;

endpackage

[rtl/core/sleb_in_if.sv]
interface sleb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/core/sleb_out_if.sv]
interface sleb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cmd_byte;
  logic       has_byte;
  logic       line_end;
  logic       overflow_seen;

  modport source (output valid, output cmd_byte, output has_byte, output line_end,
                  output overflow_seen, input ready);
  modport sink (input valid, input cmd_byte, input has_byte, input line_end,
                input overflow_seen, output ready);
endinterface

[rtl/core/serial_line_edit_buffer.sv]
// Line-editing receive buffer: received bytes enter through a two-word queue and
// are stored, edited (backspace, escape) or executed (carriage return) one word per
// cycle outside a line drain, so ordinary characters are taken every cycle while
// a line's last word waits at the output. A carriage return drains the pending
// line oldest first, each byte read from the line memory into a register and then
// loaded into the output register once free; an empty line yields one terminator
// word. At most BUFFER_DEPTH - 1 bytes are pending; further bytes are dropped and
// flagged on the line's last word. The line memory needs no clearing after reset.
module serial_line_edit_buffer
  import sleb_pkg::*;
#(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  sleb_in_if.sink    in_ch,
  sleb_out_if.source out_ch
);

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  sleb_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  sleb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  sleb_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

[rtl/core/sleb_front.sv]
module sleb_front
  import sleb_pkg::*;
(
  sleb_in_if.sink in_ch,
  output logic    push_valid,
  output cmd_t    push_cmd,
  input  logic    push_ready
);

  logic ignored;

  // '$' and '?' are consumed without reaching the queue
  assign ignored = (in_ch.rx_byte == CH_DOLLAR) || (in_ch.rx_byte == CH_QUESTION);

  always_comb begin
    push_cmd.data = in_ch.rx_byte;
    case (in_ch.rx_byte)
      CH_BACKSPACE: push_cmd.op = OP_BACK;
      CH_ESCAPE:    push_cmd.op = OP_ESC;
      CH_RETURN:    push_cmd.op = OP_EXEC;
      default:      push_cmd.op = OP_STORE;
    endcase
  end

  assign push_valid  = in_ch.valid && !ignored;
  assign in_ch.ready = push_ready;

endmodule

[rtl/core/sleb_queue.sv]
module sleb_queue
  import sleb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop_ready
);

  cmd_t       slot_r [2];
  logic       head_r, head_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;
  logic       wr_idx;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = slot_r[head_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign wr_idx     = head_r ^ count_r[0];

  always_comb begin
    head_nxt  = pop ? ~head_r : head_r;
    count_nxt = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_idx] <= push_cmd;
    end
  end

endmodule

[rtl/core/sleb_back.sv]
module sleb_back
  import sleb_pkg::*;
#(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_ready,
  sleb_out_if.source  out_ch
);

  localparam int PW = $clog2(BUFFER_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(BUFFER_DEPTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_TERM = 2'd3;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
    ring_prev = (p == '0) ? LAST_SLOT : p - 1'b1;
  endfunction

  logic [7:0]    mem [BUFFER_DEPTH];
  logic [7:0]    rdata_r;
  logic [1:0]    state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt;
  logic          ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_has_r, out_has_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;
  logic          load;
  logic          slot_free;
  logic          mem_we;
  logic [PW-1:0] wp_inc;
  logic          is_last;

  assign cmd_ready = (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign wp_inc    = ring_next(wp_r);
  assign is_last   = (ptr_r == wp_r);

  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    ptr_nxt      = ptr_r;
    ovf_nxt      = ovf_r;
    mem_we       = 1'b0;
    load         = 1'b0;
    out_byte_nxt = out_byte_r;
    out_has_nxt  = out_has_r;
    out_last_nxt = out_last_r;
    out_ovf_nxt  = out_ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_STORE: begin
              if (wp_inc == rp_r) begin
                ovf_nxt = 1'b1;
              end else begin
                wp_nxt = wp_inc;
                mem_we = 1'b1;
              end
            end
            OP_BACK: begin
              if (wp_r != rp_r) begin
                wp_nxt = ring_prev(wp_r);
              end
            end
            OP_ESC: begin
              wp_nxt = rp_r;
            end
            OP_EXEC: begin
              if (wp_r == rp_r) begin
                state_nxt = ST_TERM;
              end else begin
                ptr_nxt   = rp_r;
                state_nxt = ST_READ;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        ptr_nxt   = ring_next(ptr_r);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          load         = 1'b1;
          out_byte_nxt = rdata_r;
          out_has_nxt  = 1'b1;
          out_last_nxt = is_last;
          out_ovf_nxt  = is_last && ovf_r;
          if (is_last) begin
            rp_nxt    = wp_r;
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_TERM: begin
        if (slot_free) begin
          load         = 1'b1;
          out_byte_nxt = 8'd0;
          out_has_nxt  = 1'b0;
          out_last_nxt = 1'b1;
          out_ovf_nxt  = ovf_r;
          ovf_nxt      = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = load || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      ptr_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      ptr_r       <= ptr_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_has_r  <= out_has_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // line memory, one write and one registered read port
  // read data is held while the output stalls
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_inc] <= cmd.data;
    end
    if (state_r == ST_READ) begin
      rdata_r <= mem[ring_next(ptr_r)];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cmd_byte      = out_byte_r;
  assign out_ch.has_byte      = out_has_r;
  assign out_ch.line_end      = out_last_r;
  assign out_ch.overflow_seen = out_ovf_r;

endmodule

[rtl/core/sleb_checker.sv]
module sleb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_cmd_byte,
  input logic       out_has_byte,
  input logic       out_line_end,
  input logic       out_overflow_seen
);

  // nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn while stalled");

  // empty-line terminator is always a line end with a zero byte
  a_term_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_line_end && (out_cmd_byte == 8'd0))
    else $error("malformed terminator word");

  a_ovf_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow_seen |-> out_line_end)
    else $error("overflow flag off the line end");

endmodule

bind serial_line_edit_buffer sleb_checker u_sleb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_cmd_byte      (out_ch.cmd_byte),
  .out_has_byte      (out_ch.has_byte),
  .out_line_end      (out_ch.line_end),
  .out_overflow_seen (out_ch.overflow_seen)
);

[tb/tb_serial_line_edit_buffer.sv]
module tb_serial_line_edit_buffer;
  import sleb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam int PW = $clog2(DEPTH);

  typedef struct packed {
    logic [7:0] cmd_byte;
    logic       has_byte;
    logic       line_end;
    logic       overflow_seen;
  } cmd_word_t;

  logic clk;
  logic rst_n;

  sleb_in_if  in_bus ();
  sleb_out_if out_bus ();

  serial_line_edit_buffer #(
    .BUFFER_DEPTH(DEPTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus.sink),
    .out_ch(out_bus.source)
  );

  // predicted line state
  logic [7:0]    line_ring [DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic          drop_flag;
  cmd_word_t     line_words [$];

  int errors;
  bit idle_on;
  bit stall_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void edit_line(input logic [7:0] b);
    logic [PW-1:0] p;
    logic [PW-1:0] nxt;
    cmd_word_t     w;
    if (b == CH_BACKSPACE) begin
      if (head != tail) head = head - 1'b1;
    end else if (b == CH_ESCAPE) begin
      head = tail;
    end else if (b == CH_RETURN) begin
      if (head == tail) begin
        w = '{cmd_byte: 8'h00, has_byte: 1'b0, line_end: 1'b1, overflow_seen: drop_flag};
        line_words.push_back(w);
      end else begin
        p = tail;
        while (p != head) begin
          p = p + 1'b1;
          w.cmd_byte      = line_ring[p];
          w.has_byte      = 1'b1;
          w.line_end      = (p == head);
          w.overflow_seen = (p == head) ? drop_flag : 1'b0;
          line_words.push_back(w);
        end
      end
      tail = head;
      drop_flag = 1'b0;
    end else if (b != CH_DOLLAR && b != CH_QUESTION) begin
      nxt = head + 1'b1;
      if (nxt == tail) begin
        drop_flag = 1'b1;
      end else begin
        head = nxt;
        line_ring[nxt] = b;
      end
    end
  endfunction

  task automatic send_char(input logic [7:0] b);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk);
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    edit_line(b);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (line_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] storable_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_BACKSPACE || c == CH_ESCAPE || c == CH_RETURN ||
           c == CH_DOLLAR || c == CH_QUESTION);
    return c;
  endfunction

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return CH_BACKSPACE;
    if (r < 10) return CH_ESCAPE;
    if (r < 15) return ($urandom_range(0, 1) != 0) ? CH_DOLLAR : CH_QUESTION;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // result checker
  initial begin
    cmd_word_t w;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (line_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none actual %h/%b/%b/%b", $time,
                   out_bus.cmd_byte, out_bus.has_byte, out_bus.line_end,
                   out_bus.overflow_seen);
        end else begin
          w = line_words.pop_front();
          check_field("cmd_byte", w.cmd_byte, out_bus.cmd_byte);
          check_field("has_byte", 8'(w.has_byte), 8'(out_bus.has_byte));
          check_field("line_end", 8'(w.line_end), 8'(out_bus.line_end));
          check_field("overflow_seen", 8'(w.overflow_seen), 8'(out_bus.overflow_seen));
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int n;
    forever begin
      n = $urandom_range(1, 10);
      if (stall_on && $urandom_range(0, 2) == 0) begin
        repeat (n) begin
          @(negedge clk);
          out_bus.ready <= 1'b0;
        end
      end else begin
        repeat (n) begin
          @(negedge clk);
          out_bus.ready <= 1'b1;
        end
      end
    end
  end

  task automatic test_empty_line();
    send_char(CH_RETURN);
    send_char(CH_BACKSPACE);
    send_char(CH_ESCAPE);
    send_char(CH_RETURN);
  endtask

  task automatic test_field_extremes();
    send_char(8'h00);
    send_char(8'hff);
    send_char(8'h80);
    send_char(8'h7f);
    send_char(8'h01);
    send_char(CH_RETURN);
  endtask

  task automatic test_ignored_chars();
    send_char("a");
    send_char(CH_DOLLAR);
    send_char(CH_QUESTION);
    send_char("b");
    send_char(CH_RETURN);
  endtask

  task automatic test_line_edits();
    send_char("a");
    send_char("b");
    send_char(CH_BACKSPACE);
    send_char("c");
    send_char(CH_RETURN);
    send_char("x");
    send_char("y");
    send_char(CH_ESCAPE);
    send_char("z");
    send_char(CH_RETURN);
  endtask

  task automatic test_full_ring();
    // fill and drop one, escape keeps the drop flag for the empty-line terminator
    repeat (DEPTH) send_char(storable_char());
    send_char(CH_ESCAPE);
    send_char(CH_RETURN);
    // full line with overflow on its last word
    repeat (DEPTH) send_char(storable_char());
    send_char(CH_RETURN);
  endtask

  task automatic test_random_lines(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      repeat (len) send_char(pick_char());
      if ($urandom_range(0, 19) != 0) send_char(CH_RETURN);
      sent += len + 1;
    end
  endtask

  task automatic test_back_to_back();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    test_random_lines(8);
    send_char(CH_RETURN);
  endtask

  initial begin
    errors = 0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    head = '0;
    tail = '0;
    drop_flag = 1'b0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.rx_byte = 8'h00;
    out_bus.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_line();
    test_field_extremes();
    test_ignored_chars();
    test_line_edits();
    test_full_ring();
    test_random_lines(12);
    test_back_to_back();

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0 && line_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/sleb_pkg.sv
rtl/core/sleb_in_if.sv
rtl/core/sleb_out_if.sv
rtl/core/sleb_front.sv
rtl/core/sleb_queue.sv
rtl/core/sleb_back.sv
rtl/core/serial_line_edit_buffer.sv
rtl/core/sleb_checker.sv
tb/tb_serial_line_edit_buffer.sv
